// ===== design/far_pkg.sv =====
package far_pkg;

  localparam int ACT_W     = 2;
  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;
  localparam int OUT_W     = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ===== design/far_alu.sv =====
module far_alu #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0]  a,
  input  logic [WIDTH-1:0]  b,
  input  far_pkg::alu_op_t  op,
  output logic [WIDTH-1:0]  res,
  output logic              ge
);
  import far_pkg::*;

  logic [WIDTH:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[WIDTH];
  assign res  = (op == ALU_SUB) ? diff[WIDTH-1:0] : a + b;

endmodule

// ===== design/fraction_arith_reduce_unit.sv =====
// channel | dir | tdata (low bit up)                              | tuser
// s_*     | in  | first_num, first_den, second_num, second_den    | action
// m_*     | out | result_num[31:0], result_den[62:32], pad[63]    | div_zero
//
// One beat in, one beat out. Per item: the cross products on one multiplier, the
// add/sub combine, a binary GCD of one compare/subtract step per cycle, the GCD
// shift restore, then two restoring divisions of MW quotient bits each
// (MW = 2*OPERAND_WIDTH) on the same shared subtractor.
// A zero or undefined result skips GCD and divisions.
// s_tready is high only while idle.
// A finished result waits in the output register; a stalled m_tready holds
// the sequencer in its last state. rst is synchronous, active high.
module fraction_arith_reduce_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // first_num, first_den, second_num, second_den, zero pad
  input  logic [((4*OPERAND_WIDTH+5)/8)*8-1:0]   s_tdata,
  // action
  input  logic [far_pkg::ACT_W-1:0]              s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // result_num, result_den, zero pad
  output logic [far_pkg::OUT_W-1:0]              m_tdata,
  // div_zero
  output logic [0:0]                             m_tuser
);
  import far_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(MW);
  localparam int XW = (MW > RES_NUM_W) ? MW : RES_NUM_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_CMP  = 10'b0000000100,
    S_DIFF = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_GTWO = 10'b0000100000,
    S_GCD  = 10'b0001000000,
    S_GSH  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t          state;
  action_t         op;
  logic [W-1:0]    m1;
  logic [W-1:0]    m2;
  logic [W-2:0]    d1;
  logic [W-2:0]    d2;
  logic            s1;
  logic            s2;
  logic [1:0]      mstep;
  logic [MW-1:0]   pa;
  logic [MW-1:0]   pb;
  logic [MW-1:0]   nm;
  logic [MW-1:0]   dm;
  logic            nneg;
  logic            err;
  logic            ge_q;
  logic [MW-1:0]   gx;
  logic [MW-1:0]   gy;
  logic [CW-1:0]   gk;
  logic [MW-1:0]   dq;
  logic [MW-1:0]   dr;
  logic [CW-1:0]   dcnt;
  logic            dsel;

  logic [W-1:0]    in_n1;
  logic [W-1:0]    in_n2;
  logic [W-1:0]    mul_a;
  logic [W-1:0]    mul_b;
  logic [MW-1:0]   prod;
  logic            sb;
  logic [MW-1:0]   div_a;
  logic [MW-1:0]   q_new;
  logic [MW-1:0]   alu_a;
  logic [MW-1:0]   alu_b;
  alu_op_t         alu_op;
  logic [MW-1:0]   alu_res;
  logic            alu_ge;
  logic [XW-1:0]   ext_num;
  logic [XW-1:0]   sgn_num;
  logic [XW-1:0]   ext_den;
  logic            out_load;

  assign s_tready = (state == S_IDLE);

  assign in_n1 = s_tdata[W-1:0];
  assign in_n2 = s_tdata[3*W-2:2*W-1];

  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a = m1;
        mul_b = (op == ACT_MUL) ? m2 : {1'b0, d2};
      end
      2'd1: begin
        mul_a = m2;
        mul_b = {1'b0, d1};
      end
      default: begin
        mul_a = {1'b0, d1};
        mul_b = {1'b0, d2};
      end
    endcase
  end

  assign prod  = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
  assign sb    = (op == ACT_SUB) ? ~s2 : s2;
  assign div_a = {dr[MW-2:0], dq[MW-1]};
  assign q_new = {dq[MW-2:0], alu_ge};

  always_comb begin
    alu_a  = pa;
    alu_b  = pb;
    alu_op = ALU_SUB;
    case (state)
      S_CMP: begin
        alu_op = (s1 == sb) ? ALU_ADD : ALU_SUB;
      end
      S_DIFF: begin
        alu_a = ge_q ? pa : pb;
        alu_b = ge_q ? pb : pa;
      end
      S_GCD: begin
        alu_a = gx;
        alu_b = gy;
      end
      S_DIV: begin
        alu_a = div_a;
        alu_b = gy;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  far_alu #(.WIDTH(MW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res),
    .ge  (alu_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= 2'd0;
      dsel  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= action_t'(s_tuser);
            s1    <= in_n1[W-1];
            m1    <= in_n1[W-1] ? (~in_n1 + 1'b1) : in_n1;
            d1    <= s_tdata[2*W-2:W];
            s2    <= in_n2[W-1];
            m2    <= in_n2[W-1] ? (~in_n2 + 1'b1) : in_n2;
            d2    <= s_tdata[4*W-3:3*W-1];
            mstep <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: begin
              pa    <= prod;
              mstep <= 2'd1;
            end
            2'd1: begin
              pb    <= prod;
              mstep <= 2'd2;
            end
            default: begin
              mstep <= 2'd0;
              dm    <= (op == ACT_DIV) ? pb : prod;
              if (op == ACT_ADD || op == ACT_SUB) begin
                state <= S_CMP;
              end else begin
                nm    <= pa;
                nneg  <= s1 ^ s2;
                state <= S_CHK;
              end
            end
          endcase
        end
        S_CMP: begin
          if (s1 == sb) begin
            nm    <= alu_res;
            nneg  <= s1;
            state <= S_CHK;
          end else begin
            ge_q  <= alu_ge;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          nm    <= alu_res;
          nneg  <= ge_q ? s1 : sb;
          state <= S_CHK;
        end
        S_CHK: begin
          if (dm == '0) begin
            nm    <= '0;
            nneg  <= 1'b0;
            err   <= 1'b1;
            state <= S_OUT;
          end else if (nm == '0) begin
            dm    <= MW'(1);
            nneg  <= 1'b0;
            err   <= 1'b0;
            state <= S_OUT;
          end else begin
            gx    <= nm;
            gy    <= dm;
            gk    <= '0;
            err   <= 1'b0;
            state <= S_GTWO;
          end
        end
        S_GTWO: begin
          if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            gk <= gk + 1'b1;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gx == '0) begin
            state <= S_GSH;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (alu_ge) begin
            gx <= alu_res >> 1;
          end else begin
            gx <= gy;
            gy <= gx;
          end
        end
        S_GSH: begin
          if (gk == '0) begin
            dq    <= nm;
            dr    <= '0;
            dcnt  <= '0;
            dsel  <= 1'b0;
            state <= S_DIV;
          end else begin
            gy <= gy << 1;
            gk <= gk - 1'b1;
          end
        end
        S_DIV: begin
          if (dcnt == CW'(MW - 1)) begin
            dcnt <= '0;
            if (!dsel) begin
              nm   <= q_new;
              dq   <= dm;
              dr   <= '0;
              dsel <= 1'b1;
            end else begin
              dm    <= q_new;
              dsel  <= 1'b0;
              state <= S_OUT;
            end
          end else begin
            dr   <= alu_ge ? alu_res : div_a;
            dq   <= q_new;
            dcnt <= dcnt + 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  assign ext_num  = XW'(nm);
  assign sgn_num  = nneg ? (XW'(0) - ext_num) : ext_num;
  assign ext_den  = XW'(dm);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, ext_den[RES_DEN_W-1:0], sgn_num[RES_NUM_W-1:0]};
      m_tuser <= err;
    end
  end

endmodule

// ===== design/far_checker.sv =====
module far_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [far_pkg::OUT_W-1:0] m_tdata,
  input logic [0:0]                m_tuser
);
  import far_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after an accepted beat");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("div_zero result carries nonzero data");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] != '0)
    else $error("zero denominator without div_zero");

endmodule

bind fraction_arith_reduce_unit far_checker u_far_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/fraction_arith_reduce_unit_tb.sv =====
`timescale 1ns / 100ps

module fraction_arith_reduce_unit_tb;
  import far_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int NDIR         = 25;
  // whole-run watchdog: every item at worst case plus both sides' gaps and the long hold, with margin
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 300;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               div_zero;
  } fraction_t;

  typedef struct {
    action_t act;
    int      n1;
    int      d1;
    int      n2;
    int      d2;
    bit      typed;
    int      rnum;
    int      rden;
    bit      rdz;
  } operand_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  fraction_t expected_fractions[$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;

  operand_row_t directed_rows [0:NDIR-1] = '{
    '{ACT_ADD, 0, 1, 0, 1, 1'b1, 0, 1, 1'b0},
    '{ACT_ADD, 1, 1, 1, 1, 1'b1, 2, 1, 1'b0},
    '{ACT_SUB, 1, 2, 1, 2, 1'b1, 0, 1, 1'b0},
    '{ACT_MUL, 3, 4, 0, 5, 1'b1, 0, 1, 1'b0},
    '{ACT_DIV, 1, 1, 0, 1, 1'b1, 0, 0, 1'b1},
    '{ACT_DIV, -32768, 1, 0, 32767, 1'b1, 0, 0, 1'b1},
    '{ACT_ADD, 5, 0, 1, 3, 1'b1, 0, 0, 1'b1},
    '{ACT_MUL, 5, 3, 1, 0, 1'b1, 0, 0, 1'b1},
    '{ACT_DIV, 1, 0, 2, 3, 1'b1, 0, 0, 1'b1},
    '{ACT_DIV, 1, 2, 3, 0, 1'b1, 0, 1, 1'b0},
    '{ACT_MUL, -32768, 1, -32768, 1, 1'b1, 1073741824, 1, 1'b0},
    '{ACT_DIV, -32768, 1, 1, 32767, 1'b1, -1073709056, 1, 1'b0},
    '{ACT_DIV, 1, 32767, -32768, 1, 1'b1, -1, 1073709056, 1'b0},
    '{ACT_MUL, 1, 32767, 1, 32767, 1'b1, 1, 1073676289, 1'b0},
    '{ACT_ADD, 32767, 1, 32767, 1, 1'b1, 65534, 1, 1'b0},
    '{ACT_SUB, -32768, 1, 32767, 1, 1'b1, -65535, 1, 1'b0},
    '{ACT_ADD, -32768, 32767, -32768, 32767, 1'b1, -65536, 32767, 1'b0},
    '{ACT_ADD, 6, 4, 1, 4, 1'b0, 0, 0, 1'b0},
    '{ACT_SUB, 2, 3, 3, 4, 1'b0, 0, 0, 1'b0},
    '{ACT_MUL, -6, 35, 14, 9, 1'b0, 0, 0, 1'b0},
    '{ACT_DIV, 3, 7, -9, 14, 1'b0, 0, 0, 1'b0},
    '{ACT_SUB, 12345, 6789, -4321, 1000, 1'b0, 0, 0, 1'b0},
    '{ACT_DIV, 32767, 32767, 32767, 32767, 1'b1, 1, 1, 1'b0},
    '{ACT_SUB, 21845, 10922, -21846, 21845, 1'b0, 0, 0, 1'b0},
    '{ACT_SUB, 0, 7, 0, 9, 1'b1, 0, 1, 1'b0}
  };

  fraction_arith_reduce_unit #(
    .OPERAND_WIDTH(16)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fraction_t reduce_fraction(action_t act, logic [15:0] n1, logic [14:0] d1,
                                                logic [15:0] n2, logic [14:0] d2);
    fraction_t res;
    longint unsigned m1, m2, a, b, nmag, dmag, x, y, r;
    bit s1, s2, sb, neg;
    s1 = n1[15];
    s2 = n2[15];
    m1 = s1 ? 64'd65536 - 64'(n1) : 64'(n1);
    m2 = s2 ? 64'd65536 - 64'(n2) : 64'(n2);
    case (act)
      ACT_ADD, ACT_SUB: begin
        a  = m1 * 64'(d2);
        b  = m2 * 64'(d1);
        sb = (act == ACT_SUB) ? !s2 : s2;
        if (s1 == sb) begin
          nmag = a + b;
          neg  = s1;
        end else if (a >= b) begin
          nmag = a - b;
          neg  = s1;
        end else begin
          nmag = b - a;
          neg  = sb;
        end
        dmag = 64'(d1) * 64'(d2);
      end
      ACT_MUL: begin
        nmag = m1 * m2;
        dmag = 64'(d1) * 64'(d2);
        neg  = s1 != s2;
      end
      default: begin
        nmag = m1 * 64'(d2);
        dmag = 64'(d1) * m2;
        neg  = s1 != s2;
      end
    endcase
    if (dmag == 0) begin
      res.num      = '0;
      res.den      = '0;
      res.div_zero = 1'b1;
    end else if (nmag == 0) begin
      res.num      = '0;
      res.den      = 31'd1;
      res.div_zero = 1'b0;
    end else begin
      x = nmag;
      y = dmag;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      nmag         = nmag / x;
      dmag         = dmag / x;
      res.num      = 32'(neg ? 64'd0 - nmag : nmag);
      res.den      = 31'(dmag);
      res.div_zero = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_num();
    logic [15:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hffff;
        endcase
      end
      1, 2, 3: v = 16'($signed($urandom_range(40)) - 20);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [14:0] pick_den();
    logic [14:0] v;
    case ($urandom_range(49))
      0: v = 15'd0;
      1: v = 15'd1;
      2: v = 15'h7fff;
      3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: v = 15'($urandom_range(30, 1));
      default: v = 15'($urandom_range(32767, 1));
    endcase
    return v;
  endfunction

  task automatic offer_fraction(action_t act, logic [15:0] n1, logic [14:0] d1,
                                logic [15:0] n2, logic [14:0] d2, bit typed, fraction_t fixed);
    while (!steady && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, d2, n2, d1, n1};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_fractions.push_back(typed ? fixed : reduce_fraction(act, n1, d1, n2, d2));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  // result side: check, then pick next tready
  always @(posedge clk) begin
    fraction_t want;
    if (m_tvalid && m_tready) begin
      if (expected_fractions.size() == 0) begin
        $error("result beat with nothing pending: num %0d den %0d div_zero %0d",
               $signed(m_tdata[31:0]), m_tdata[62:32], m_tuser[0]);
        errors++;
      end else begin
        want = expected_fractions.pop_front();
        if (m_tdata[31:0] !== want.num) begin
          $error("result_num expected %0d got %0d", want.num, $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[62:32] !== want.den) begin
          $error("result_den expected %0d got %0d", want.den, m_tdata[62:32]);
          errors++;
        end
        if (m_tuser[0] !== want.div_zero) begin
          $error("div_zero expected %0d got %0d", want.div_zero, m_tuser[0]);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fraction_arith_reduce_unit");
      $finish;
    end
  end

  initial begin
    fraction_t fixed;
    operand_row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      row              = directed_rows[i];
      fixed.num        = row.rnum;
      fixed.den        = 31'(row.rden);
      fixed.div_zero   = row.rdz;
      offer_fraction(row.act, 16'(row.n1), 15'(row.d1), 16'(row.n2), 15'(row.d2),
                     row.typed, fixed);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) hold_req = 1'b1;
      steady = (i >= 1000 && i < 1300);
      if (i == 1600) drain_results();
      offer_fraction(action_t'($urandom_range(3)), pick_num(), pick_den(), pick_num(),
                     pick_den(), 1'b0, fixed);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS fraction_arith_reduce_unit");
    end else begin
      $display("FAIL fraction_arith_reduce_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/far_pkg.sv
design/far_alu.sv
design/fraction_arith_reduce_unit.sv
design/far_checker.sv
bench/fraction_arith_reduce_unit_tb.sv
